>>> hdl/patrq_pkg.sv
// Shared types and constants for the per-accelerator task ring queues.
package patrq_pkg;

  localparam int MAX_ACC     = 32;
  localparam int SQ_DEPTH    = 32;
  localparam int ACC_W       = 5;
  localparam int SLOT_W      = 5;
  localparam int POS_W       = ACC_W + SLOT_W;
  localparam int TOTAL_SLOTS = MAX_ACC * SQ_DEPTH;
  localparam int CNT_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int RDY_W       = 1 + SIZE_W + 64;
  localparam int DONE_W      = 1 + 64;

  typedef enum logic [2:0] {
    OP_SUBMIT   = 3'd0,
    OP_GET_ONE  = 3'd1,
    OP_GET_ANY  = 3'd2,
    OP_TAKE     = 3'd3,
    OP_POST     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_ACC = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_SUBMIT,
    CMD_GET_ONE,
    CMD_GET_ANY,
    CMD_TAKE,
    CMD_POST,
    CMD_BAD_ACC,
    CMD_UNKNOWN
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  accel_id;
    logic [63:0] task_info_address;
    logic [5:0]  argument_count;
    logic [4:0]  slot_index;
    logic [63:0] finished_task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  result_accel_id;
    logic [4:0]  result_slot;
    logic [63:0] result_task_address;
    logic [6:0]  result_task_size;
    logic [63:0] result_task_id;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ACC_W-1:0]   acc;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        addr;
    logic [SIZE_W-1:0]  size;
    logic [63:0]        fid;
    logic [CNT_W-1:0]   n_live;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> hdl/patrq_front.sv
// Front end: holds the accelerator count and classifies each accepted item.
module patrq_front
  import patrq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  in_item_t           item,
  output cmd_t               cmd
);

  logic [CNT_W-1:0] active_r;
  logic [CNT_W-1:0] n_live;
  logic [7:0]       size_raw;
  logic             bad_acc;

  // Hold the configured accelerator count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CNT_W'(1);
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // Clamp the count to the supported range
  always_comb begin
    n_live = active_r;
    if (active_r == '0) n_live = CNT_W'(1);
    if (active_r > CNT_W'(MAX_ACC)) n_live = CNT_W'(MAX_ACC);
  end

  assign size_raw = {1'b0, item.argument_count, 1'b0} + 8'd3;
  assign bad_acc  = ({1'b0, item.accel_id} >= n_live);

  // Classify the transfer into a back-end command
  always_comb begin
    cmd.acc    = item.accel_id;
    cmd.slot   = item.slot_index;
    cmd.addr   = item.task_info_address;
    cmd.size   = size_raw[7] ? SIZE_W'(127) : size_raw[SIZE_W-1:0];
    cmd.fid    = item.finished_task_id;
    cmd.n_live = n_live;
    case (item.opcode)
      OP_GET_ANY: cmd.kind = CMD_GET_ANY;
      OP_SUBMIT:  cmd.kind = bad_acc ? CMD_BAD_ACC : CMD_SUBMIT;
      OP_GET_ONE: cmd.kind = bad_acc ? CMD_BAD_ACC : CMD_GET_ONE;
      OP_TAKE:    cmd.kind = bad_acc ? CMD_BAD_ACC : CMD_TAKE;
      OP_POST:    cmd.kind = bad_acc ? CMD_BAD_ACC : CMD_POST;
      default:    cmd.kind = CMD_UNKNOWN;
    endcase
  end

endmodule

>>> hdl/patrq_cmd_q.sv
// Two-entry command queue between the front end and the back end.
module patrq_cmd_q
  import patrq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head       = ent_r[rp_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule

>>> hdl/patrq_back.sv
// Back end: slot memories, ring indexes and the command sequencer.
module patrq_back
  import patrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      clearing,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [RDY_W-1:0]  rdy_mem [TOTAL_SLOTS];
  logic [DONE_W-1:0] done_mem [TOTAL_SLOTS];
  logic [RDY_W-1:0]  rdy_q_r;
  logic [DONE_W-1:0] done_q_r;

  logic [SLOT_W-1:0] sub_idx_r  [MAX_ACC];
  logic [SLOT_W-1:0] take_idx_r [MAX_ACC];

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0]  clr_r;
  out_item_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  logic              rdy_re, done_re, rdy_we, done_we;
  logic [POS_W-1:0]  rdy_addr, done_addr;
  logic [RDY_W-1:0]  rdy_wdata;
  logic [DONE_W-1:0] done_wdata;
  logic              sub_we, take_we;
  logic [ACC_W-1:0]  nxt_acc;

  // Read and write the ready slots
  always_ff @(posedge clk) begin
    if (rdy_we) rdy_mem[rdy_addr] <= rdy_wdata;
    if (rdy_re) rdy_q_r <= rdy_mem[rdy_addr];
  end

  // Read and write the finished slots
  always_ff @(posedge clk) begin
    if (done_we) done_mem[done_addr] <= done_wdata;
    if (done_re) done_q_r <= done_mem[done_addr];
  end

  // Hold ring indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ACC; i++) begin
        sub_idx_r[i]  <= '0;
        take_idx_r[i] <= '0;
      end
    end else begin
      if (sub_we)  sub_idx_r[acc_r]  <= idx_r + SLOT_W'(1);
      if (take_we) take_idx_r[acc_r] <= idx_r + SLOT_W'(1);
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_CLEAR;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (state_r == BK_CLEAR) clr_r <= clr_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign nxt_acc = acc_r + ACC_W'(1);

  // Next state, memory control and result
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    out_nxt     = '0;
    out_vld_nxt = 1'b0;
    pop         = 1'b0;
    rdy_re      = 1'b0;
    done_re     = 1'b0;
    rdy_we      = 1'b0;
    done_we     = 1'b0;
    rdy_addr    = {acc_r, idx_r};
    done_addr   = {acc_r, idx_r};
    rdy_wdata   = '0;
    done_wdata  = '0;
    sub_we      = 1'b0;
    take_we     = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        rdy_we    = 1'b1;
        done_we   = 1'b1;
        rdy_addr  = clr_r;
        done_addr = clr_r;
        if (clr_r == POS_W'(TOTAL_SLOTS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          acc_nxt = head.acc;
          case (head.kind)
            CMD_BAD_ACC: begin
              out_vld_nxt             = 1'b1;
              out_nxt.status          = ST_BAD_ACC;
              out_nxt.result_accel_id = head.acc;
            end
            CMD_SUBMIT: begin
              idx_nxt   = sub_idx_r[head.acc];
              rdy_addr  = {head.acc, sub_idx_r[head.acc]};
              rdy_re    = 1'b1;
              state_nxt = BK_CHECK;
            end
            CMD_GET_ONE: begin
              idx_nxt   = take_idx_r[head.acc];
              done_addr = {head.acc, take_idx_r[head.acc]};
              done_re   = 1'b1;
              state_nxt = BK_CHECK;
            end
            CMD_GET_ANY: begin
              acc_nxt   = '0;
              idx_nxt   = take_idx_r[0];
              done_addr = {ACC_W'(0), take_idx_r[0]};
              done_re   = 1'b1;
              state_nxt = BK_CHECK;
            end
            CMD_TAKE: begin
              idx_nxt   = head.slot;
              rdy_addr  = {head.acc, head.slot};
              rdy_re    = 1'b1;
              state_nxt = BK_CHECK;
            end
            CMD_POST: begin
              idx_nxt   = head.slot;
              done_addr = {head.acc, head.slot};
              done_re   = 1'b1;
              state_nxt = BK_CHECK;
            end
            default: begin
              out_vld_nxt    = 1'b1;
              out_nxt.status = ST_EMPTY;
            end
          endcase
        end
      end
      BK_CHECK: begin
        state_nxt               = BK_IDLE;
        out_vld_nxt             = 1'b1;
        out_nxt.result_accel_id = acc_r;
        out_nxt.result_slot     = idx_r;
        case (cmd_r.kind)
          CMD_SUBMIT: begin
            if (rdy_q_r[RDY_W-1]) begin
              out_nxt.status = ST_BUSY;
            end else begin
              rdy_we                      = 1'b1;
              rdy_wdata                   = {1'b1, cmd_r.size, cmd_r.addr};
              sub_we                      = 1'b1;
              out_nxt.status              = ST_OK;
              out_nxt.result_task_address = cmd_r.addr;
              out_nxt.result_task_size    = cmd_r.size;
            end
          end
          CMD_GET_ONE, CMD_GET_ANY: begin
            if (done_q_r[DONE_W-1]) begin
              done_we                = 1'b1;
              done_wdata             = {1'b0, done_q_r[63:0]};
              take_we                = 1'b1;
              out_nxt.status         = ST_OK;
              out_nxt.result_task_id = done_q_r[63:0];
            end else if (cmd_r.kind == CMD_GET_ONE) begin
              out_nxt.status = ST_EMPTY;
            end else if (({1'b0, acc_r} + CNT_W'(1)) < cmd_r.n_live) begin
              // Move the scan on to the next accelerator
              out_vld_nxt = 1'b0;
              state_nxt   = BK_CHECK;
              acc_nxt     = nxt_acc;
              idx_nxt     = take_idx_r[nxt_acc];
              done_addr   = {nxt_acc, take_idx_r[nxt_acc]};
              done_re     = 1'b1;
            end else begin
              out_nxt        = '0;
              out_nxt.status = ST_EMPTY;
            end
          end
          CMD_TAKE: begin
            if (rdy_q_r[RDY_W-1]) begin
              rdy_we                      = 1'b1;
              rdy_wdata                   = {1'b0, rdy_q_r[RDY_W-2:0]};
              out_nxt.status              = ST_OK;
              out_nxt.result_task_address = rdy_q_r[63:0];
              out_nxt.result_task_size    = rdy_q_r[RDY_W-2:64];
            end else begin
              out_nxt.status = ST_EMPTY;
            end
          end
          CMD_POST: begin
            if (done_q_r[DONE_W-1]) begin
              out_nxt.status = ST_BUSY;
            end else begin
              done_we        = 1'b1;
              done_wdata     = {1'b1, cmd_r.fid};
              out_nxt.status = ST_OK;
            end
          end
          default: begin
            out_nxt        = '0;
            out_nxt.status = ST_EMPTY;
          end
        endcase
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

>>> hdl/per_accel_task_ring_queues_core.sv
// Top level of the per-accelerator task ring queues.
// After reset the block sweeps its 1024 ready and 1024 finished slot marks, one
// of each per cycle, and holds busy high during the sweep; configuration
// writes are taken during the sweep. A transfer is taken when start is high and
// busy low, and lands in a two-entry command queue; busy is high while that
// queue is full. Each command produces exactly one result, shown with out_valid
// for one cycle and never held back. A command that names a bad accelerator or
// an unknown opcode is answered from the idle state in the back end; the others
// read the slot memory and then check it; a get from any accelerator checks one
// accelerator per cycle until one has a finished entry or none is left.
module per_accel_task_ring_queues_core
  import patrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  cmd_t    cmd, head;
  q_stat_t q_stat;
  logic    pop, clearing, push;

  assign busy = q_stat.full | clearing;
  assign push = start & ~busy;

  // Classify incoming transfers
  patrq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_item),
    .cmd       (cmd)
  );

  // Decouple front and back
  patrq_cmd_q u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Carry out commands against the rings
  patrq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> verif/per_accel_task_ring_queues_core_chk.sv
// Checker for the task ring queues: mirrors the queue state and compares results.
module per_accel_task_ring_queues_core_chk
  import patrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               outstanding
);

  logic              rdy_vld  [TOTAL_SLOTS];
  logic [63:0]       rdy_addr [TOTAL_SLOTS];
  logic [SIZE_W-1:0] rdy_size [TOTAL_SLOTS];
  logic              fin_vld  [TOTAL_SLOTS];
  logic [63:0]       fin_id   [TOTAL_SLOTS];
  logic [SLOT_W-1:0] sub_ptr  [MAX_ACC];
  logic [SLOT_W-1:0] take_ptr [MAX_ACC];
  logic [CNT_W-1:0]  live_reg;
  out_item_t         queue_results[$];

  assign outstanding = queue_results.size();

  function automatic out_item_t pack_result(status_t st, int acc, int slot,
                                            logic [63:0] addr, int size,
                                            logic [63:0] id);
    out_item_t r;
    r.status              = st;
    r.result_accel_id     = acc[ACC_W-1:0];
    r.result_slot         = slot[SLOT_W-1:0];
    r.result_task_address = addr;
    r.result_task_size    = size[SIZE_W-1:0];
    r.result_task_id      = id;
    return r;
  endfunction

  // Pop one finished entry for an accelerator; report empty if none there
  function automatic bit pop_finished(int acc, output out_item_t r);
    int pos;
    pos = acc * SQ_DEPTH + take_ptr[acc];
    if (!fin_vld[pos]) begin
      r = pack_result(ST_EMPTY, acc, take_ptr[acc], '0, 0, '0);
      return 0;
    end
    r = pack_result(ST_OK, acc, take_ptr[acc], '0, 0, fin_id[pos]);
    fin_vld[pos] = 1'b0;
    take_ptr[acc] = take_ptr[acc] + 1'b1;
    return 1;
  endfunction

  // Apply one queue command to the mirrored state and return its result
  function automatic out_item_t apply_queue_op(in_item_t it);
    out_item_t r;
    int        live;
    int        acc;
    int        slot;
    int        pos;
    int        size;
    live = (live_reg < 1) ? 1 : (live_reg > MAX_ACC) ? MAX_ACC : live_reg;
    acc  = it.accel_id;
    slot = it.slot_index;
    if (it.opcode == OP_GET_ANY) begin
      for (int a = 0; a < live; a++)
        if (pop_finished(a, r)) return r;
      return pack_result(ST_EMPTY, 0, 0, '0, 0, '0);
    end
    if (it.opcode > OP_POST) return pack_result(ST_EMPTY, 0, 0, '0, 0, '0);
    if (acc >= live) return pack_result(ST_BAD_ACC, acc, 0, '0, 0, '0);
    case (it.opcode)
      OP_SUBMIT: begin
        pos  = acc * SQ_DEPTH + sub_ptr[acc];
        size = 3 + 2 * it.argument_count;
        if (size > 127) size = 127;
        if (rdy_vld[pos]) return pack_result(ST_BUSY, acc, sub_ptr[acc], '0, 0, '0);
        rdy_addr[pos] = it.task_info_address;
        rdy_size[pos] = size[SIZE_W-1:0];
        rdy_vld[pos]  = 1'b1;
        r = pack_result(ST_OK, acc, sub_ptr[acc], it.task_info_address, size, '0);
        sub_ptr[acc] = sub_ptr[acc] + 1'b1;
        return r;
      end
      OP_GET_ONE: begin
        void'(pop_finished(acc, r));
        return r;
      end
      OP_TAKE: begin
        pos = acc * SQ_DEPTH + slot;
        if (!rdy_vld[pos]) return pack_result(ST_EMPTY, acc, slot, '0, 0, '0);
        rdy_vld[pos] = 1'b0;
        return pack_result(ST_OK, acc, slot, rdy_addr[pos], rdy_size[pos], '0);
      end
      default: begin
        pos = acc * SQ_DEPTH + slot;
        if (fin_vld[pos]) return pack_result(ST_BUSY, acc, slot, '0, 0, '0);
        fin_id[pos]  = it.finished_task_id;
        fin_vld[pos] = 1'b1;
        return pack_result(ST_OK, acc, slot, '0, 0, '0);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Track config, predict accepted transfers, compare results in order
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        rdy_vld[i] = 1'b0;
        fin_vld[i] = 1'b0;
      end
      for (int i = 0; i < MAX_ACC; i++) begin
        sub_ptr[i]  = '0;
        take_ptr[i] = '0;
      end
      live_reg = 1;
      queue_results.delete();
    end else begin
      if (cfg_we) live_reg = cfg_wdata;
      if (start && !busy) queue_results.push_back(apply_queue_op(in_item));
      if (out_valid) begin
        if (queue_results.size() == 0) begin
          $display("[%0t] result with nothing expected", $time);
          fail_count++;
        end else begin
          want = queue_results.pop_front();
          if (out_item.status != want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.result_accel_id != want.result_accel_id)
            report_mismatch("accel id", out_item.result_accel_id, want.result_accel_id);
          if (out_item.result_slot != want.result_slot)
            report_mismatch("slot", out_item.result_slot, want.result_slot);
          if (out_item.result_task_address != want.result_task_address)
            report_mismatch("task address", out_item.result_task_address,
                            want.result_task_address);
          if (out_item.result_task_size != want.result_task_size)
            report_mismatch("task size", out_item.result_task_size,
                            want.result_task_size);
          if (out_item.result_task_id != want.result_task_id)
            report_mismatch("task id", out_item.result_task_id, want.result_task_id);
        end
      end
    end
  end

endmodule

>>> verif/per_accel_task_ring_queues_core_tb.sv
// Stimulus and verdict for the per-accelerator task ring queues.
module per_accel_task_ring_queues_core_tb;
  import patrq_pkg::*;

  localparam int IDLE_LIMIT = 6000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               outstanding;
  int               live;
  bit               allow_gaps = 1'b1;
  int               submits_sent [MAX_ACC];
  int               posts_sent   [MAX_ACC];
  int               quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  per_accel_task_ring_queues_core u_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item, .cfg_we, .cfg_wdata
  );

  per_accel_task_ring_queues_core_chk u_chk (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item, .cfg_we, .cfg_wdata,
    .fail_count, .outstanding
  );

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("per_accel_task_ring_queues_core_tb failed");
      $finish;
    end
  end

  // Hold one command until the block takes the transfer, then idle at random
  task automatic issue(op_t op, int acc, logic [63:0] addr, int args, int slot,
                       logic [63:0] id);
    in_item_t it;
    it.opcode            = op;
    it.accel_id          = acc[ACC_W-1:0];
    it.task_info_address = addr;
    it.argument_count    = args[CNT_W-1:0];
    it.slot_index        = slot[SLOT_W-1:0];
    it.finished_task_id  = id;
    if (op == OP_SUBMIT) submits_sent[acc % MAX_ACC]++;
    if (op == OP_POST) posts_sent[acc % MAX_ACC]++;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Write the active count once the block has drained
  task automatic set_live(int value);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    live = (value < 1) ? 1 : (value > MAX_ACC) ? MAX_ACC : value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed traffic aimed at slots that were recently filled
  task automatic random_command();
    int pick;
    int acc;
    int slot;
    op_t op;
    pick = $urandom_range(0, 99);
    acc  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, live - 1);
    slot = $urandom_range(0, 31);
    if (pick < 30) op = OP_SUBMIT;
    else if (pick < 52) begin
      op = OP_POST;
      if ($urandom_range(0, 4) != 0) slot = posts_sent[acc] % SQ_DEPTH;
    end else if (pick < 68) op = OP_GET_ONE;
    else if (pick < 78) op = OP_GET_ANY;
    else if (pick < 96) begin
      op = OP_TAKE;
      if ($urandom_range(0, 4) != 0)
        slot = (submits_sent[acc] - 1 - $urandom_range(0, 3)) & (SQ_DEPTH - 1);
    end else op = op_t'($urandom_range(5, 7));
    issue(op, acc, rand64(), $urandom_range(0, 63), slot, rand64());
  endtask

  initial begin
    int settings [7];
    settings = '{32, 4, 0, 63, 17, 2, 1};
    foreach (submits_sent[i]) begin
      submits_sent[i] = 0;
      posts_sent[i]   = 0;
    end
    live = 1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes and each corner case, with one accelerator live
    issue(OP_SUBMIT, 0, '1, 0, 0, '0);
    issue(OP_SUBMIT, 0, '0, 62, 0, '0);
    issue(OP_SUBMIT, 0, 64'h8000_0000_0000_0001, 63, 31, '1);
    issue(OP_TAKE, 0, '0, 0, 0, '0);
    issue(OP_TAKE, 0, '0, 0, 0, '0);
    issue(OP_TAKE, 0, '0, 0, 2, '0);
    issue(OP_TAKE, 0, '0, 0, 31, '0);
    issue(OP_GET_ONE, 0, '0, 0, 0, '0);
    issue(OP_GET_ANY, 31, '0, 0, 0, '0);
    issue(OP_POST, 0, '0, 0, 0, '1);
    issue(OP_POST, 0, '0, 0, 0, 64'h1234);
    issue(OP_POST, 0, '0, 0, 1, '0);
    issue(OP_GET_ONE, 0, '0, 0, 0, '0);
    issue(OP_GET_ANY, 0, '0, 0, 0, '0);
    issue(OP_GET_ANY, 0, '0, 0, 0, '0);
    issue(OP_SUBMIT, 31, '1, 5, 0, '0);
    issue(OP_GET_ONE, 1, '0, 0, 0, '0);
    issue(OP_TAKE, 16, '0, 0, 0, '0);
    issue(OP_POST, 31, '0, 0, 31, '1);
    issue(op_t'(5), 0, '1, 63, 31, '1);
    issue(op_t'(6), 31, '0, 0, 0, '0);
    issue(op_t'(7), 7, '1, 1, 1, '1);

    // Random phases across several active counts, extremes included
    foreach (settings[s]) begin
      set_live(settings[s]);
      if (s == 6) allow_gaps = 1'b0;
      repeat (204) random_command();
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("per_accel_task_ring_queues_core_tb passed");
    else $display("per_accel_task_ring_queues_core_tb failed");
    $finish;
  end

endmodule
